>>> sv/bol_pkg.sv
// Shared types and constants for the bounded ordered list.
package bol_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W = 32;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int OUT_CNT_W = 5;

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_BACK   = 3'd3;
	localparam logic [2:0] OP_REMOVE     = 3'd4;

	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_TAKE_LEFT,
		CELL_TAKE_RIGHT,
		CELL_LOAD
	} cell_op_t;

	typedef struct packed {
		cell_op_t [CAPACITY-1:0]    op;
		logic signed [DATA_W-1:0]   value;
	} chain_ctrl_t;

endpackage

>>> sv/bol_if.sv
// Request and response channel interfaces for the bounded ordered list.
interface bol_req_if;
	logic                valid;
	logic                ready;
	logic [2:0]          operation;
	logic signed [31:0]  value;

	modport source (output valid, output operation, output value, input ready);
	modport sink (input valid, input operation, input value, output ready);
endinterface

interface bol_rsp_if;
	logic                valid;
	logic                ready;
	logic [1:0]          status;
	logic [4:0]          count;
	logic [4:0]          removed_count;
	logic signed [31:0]  front_value;
	logic signed [31:0]  back_value;

	modport source (output valid, output status, output count, output removed_count,
		output front_value, output back_value, input ready);
	modport sink (input valid, input status, input count, input removed_count,
		input front_value, input back_value, output ready);
endinterface

>>> sv/bol_cell.sv
// One list slot: holds a value, takes from a neighbor or loads, flags a match.
module bol_cell (
	input  logic                        clk,
	input  bol_pkg::cell_op_t           op,
	input  logic signed [31:0]          from_left,
	input  logic signed [31:0]          from_right,
	input  logic signed [31:0]          value,
	output logic signed [31:0]          data,
	output logic                        match
);
	import bol_pkg::*;

	logic signed [DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		case (op)
			CELL_TAKE_LEFT:  data_q <= from_left;
			CELL_TAKE_RIGHT: data_q <= from_right;
			CELL_LOAD:       data_q <= value;
			default:         data_q <= data_q;
		endcase
	end

	assign data  = data_q;
	assign match = (data_q == value);

endmodule

>>> sv/bol_chain.sv
// Row of list cells linked to their neighbors, front at cell 0.
module bol_chain (
	input  logic                        clk,
	input  bol_pkg::chain_ctrl_t        ctrl,
	output logic signed [31:0]          data [bol_pkg::CAPACITY],
	output logic [bol_pkg::CAPACITY-1:0] match
);
	import bol_pkg::*;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_in;
		logic signed [DATA_W-1:0] right_in;

		if (i == 0) begin : g_first
			assign left_in = ctrl.value;
		end else begin : g_mid_l
			assign left_in = data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_in = data[i];
		end else begin : g_mid_r
			assign right_in = data[i+1];
		end

		bol_cell u_cell (
			.clk        (clk),
			.op         (ctrl.op[i]),
			.from_left  (left_in),
			.from_right (right_in),
			.value      (ctrl.value),
			.data       (data[i]),
			.match      (match[i])
		);
	end

endmodule

>>> sv/bounded_ordered_list_core.sv
// Top level of the bounded ordered list: request control, cell chain, response register.
//
// Channels: req carries operation and value; rsp returns status, count,
// removed_count, front_value and back_value. Each channel transfers when
// valid and ready are both high at a rising edge of clk.
// One request is worked on at a time: req.ready is high only while idle.
// Push and pop pass from the run state to the report state, which loads rsp.
// Remove by value walks a scan pointer from the front, one cell per cycle
// while no cell matches; a match holds the pointer and shifts every cell
// behind it one place toward the front.
// The response register parts the two sides: a new request is taken while a
// result waits; a finished request holds in its report step until the
// response register is free.
// Reset (arst_n low) empties the list and drops any pending response; the
// slot contents are not cleared and are never read before written.
module bounded_ordered_list_core (
	input  logic    clk,
	input  logic    arst_n,
	bol_req_if.sink   req,
	bol_rsp_if.source rsp
);
	import bol_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_RUN    = 4'b0010,
		ST_SCAN   = 4'b0100,
		ST_REPORT = 4'b1000
	} state_t;

	state_t                   state_q, state_d;
	logic [CNT_W-1:0]         cnt_q, cnt_d;
	logic [CNT_W-1:0]         ptr_q, ptr_d;
	logic [CNT_W-1:0]         rem_q, rem_d;
	logic [1:0]               stat_q, stat_d;
	logic [2:0]               op_q;
	logic signed [DATA_W-1:0] val_q;

	chain_ctrl_t              ctrl;
	logic signed [DATA_W-1:0] cell_data [CAPACITY];
	logic [CAPACITY-1:0]      cell_match;

	logic                     full;
	logic                     empty;
	logic [CNT_W-1:0]         cnt_m1;
	logic                     rsp_load;

	logic                     rsp_valid_q;
	logic [1:0]               rsp_status_q;
	logic [OUT_CNT_W-1:0]     rsp_count_q;
	logic [OUT_CNT_W-1:0]     rsp_removed_q;
	logic signed [DATA_W-1:0] rsp_front_q;
	logic signed [DATA_W-1:0] rsp_back_q;

	assign full   = (cnt_q == CAP_CNT);
	assign empty  = (cnt_q == '0);
	assign cnt_m1 = cnt_q - CNT_W'(1);

	assign req.ready = (state_q == ST_IDLE);
	assign rsp_load  = (state_q == ST_REPORT) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		ptr_d      = ptr_q;
		rem_d      = rem_q;
		stat_d     = stat_q;
		ctrl.value = val_q;
		for (int i = 0; i < CAPACITY; i++) begin
			ctrl.op[i] = CELL_HOLD;
		end

		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_RUN;
					ptr_d   = '0;
					rem_d   = '0;
					stat_d  = STAT_DONE;
				end
			end
			ST_RUN: begin
				state_d = ST_REPORT;
				case (op_q)
					OP_PUSH_FRONT: begin
						if (full) begin
							stat_d = STAT_FULL;
						end else begin
							for (int i = 0; i < CAPACITY; i++) begin
								ctrl.op[i] = CELL_TAKE_LEFT;
							end
							cnt_d = cnt_q + CNT_W'(1);
						end
					end
					OP_PUSH_BACK: begin
						if (full) begin
							stat_d = STAT_FULL;
						end else begin
							for (int i = 0; i < CAPACITY; i++) begin
								if (CNT_W'(i) == cnt_q) ctrl.op[i] = CELL_LOAD;
							end
							cnt_d = cnt_q + CNT_W'(1);
						end
					end
					OP_POP_FRONT: begin
						if (empty) begin
							stat_d = STAT_EMPTY;
						end else begin
							for (int i = 0; i < CAPACITY; i++) begin
								ctrl.op[i] = CELL_TAKE_RIGHT;
							end
							cnt_d = cnt_m1;
							rem_d = CNT_W'(1);
						end
					end
					OP_POP_BACK: begin
						if (empty) begin
							stat_d = STAT_EMPTY;
						end else begin
							cnt_d = cnt_m1;
							rem_d = CNT_W'(1);
						end
					end
					OP_REMOVE: begin
						if (empty) begin
							stat_d = STAT_EMPTY;
						end else begin
							state_d = ST_SCAN;
						end
					end
					default: ;
				endcase
			end
			ST_SCAN: begin
				if (ptr_q == cnt_q) begin
					state_d = ST_REPORT;
				end else if (cell_match[ptr_q[IDX_W-1:0]]) begin
					for (int i = 0; i < CAPACITY; i++) begin
						if (CNT_W'(i) >= ptr_q) ctrl.op[i] = CELL_TAKE_RIGHT;
					end
					cnt_d = cnt_m1;
					rem_d = rem_q + CNT_W'(1);
				end else begin
					ptr_d = ptr_q + CNT_W'(1);
				end
			end
			ST_REPORT: begin
				if (rsp_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ptr_q   <= '0;
			rem_q   <= '0;
			stat_q  <= STAT_DONE;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			ptr_q   <= ptr_d;
			rem_q   <= rem_d;
			stat_q  <= stat_d;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q  <= req.operation;
			val_q <= req.value;
		end
	end

	bol_chain u_chain (
		.clk   (clk),
		.ctrl  (ctrl),
		.data  (cell_data),
		.match (cell_match)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_status_q  <= stat_q;
			rsp_count_q   <= OUT_CNT_W'(cnt_q);
			rsp_removed_q <= OUT_CNT_W'(rem_q);
			if (empty) begin
				rsp_front_q <= '0;
				rsp_back_q  <= '0;
			end else begin
				rsp_front_q <= cell_data[0];
				rsp_back_q  <= cell_data[cnt_m1[IDX_W-1:0]];
			end
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.count         = rsp_count_q;
	assign rsp.removed_count = rsp_removed_q;
	assign rsp.front_value   = rsp_front_q;
	assign rsp.back_value    = rsp_back_q;

endmodule
